// File: rtl/geometric_factor_tensor_defines.svh
// ----------------------------------------------------------------------------
// Geometric factor tensor assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GEOMETRIC_FACTOR_TENSOR_DEFINES_SVH
`define GEOMETRIC_FACTOR_TENSOR_DEFINES_SVH

// Same-cycle implication.
`define GFT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay.
`define GFT_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// File: rtl/gft_pkg.sv
// ----------------------------------------------------------------------------
// Geometric factor tensor package
// Beat types, widths, latency helpers and saturation limits.
// ----------------------------------------------------------------------------
`default_nettype none

package gft_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int JAC_W         = 32;
  localparam int WEIGHT_W      = 20;
  localparam int GEO_W         = 64;
  localparam int LIMB_W        = 32;
  localparam int DIV_LAT       = GEO_W + 3;

  localparam logic [GEO_W-1:0] Q_MAX = {1'b0, {(GEO_W-1){1'b1}}};
  localparam logic [GEO_W-1:0] Q_MIN = {1'b1, {(GEO_W-1){1'b0}}};

  typedef struct packed {
    logic signed [JAC_W-1:0]  jac_00;
    logic signed [JAC_W-1:0]  jac_01;
    logic signed [JAC_W-1:0]  jac_02;
    logic signed [JAC_W-1:0]  jac_10;
    logic signed [JAC_W-1:0]  jac_11;
    logic signed [JAC_W-1:0]  jac_12;
    logic signed [JAC_W-1:0]  jac_20;
    logic signed [JAC_W-1:0]  jac_21;
    logic signed [JAC_W-1:0]  jac_22;
    logic [WEIGHT_W-1:0]      quad_weight;
    logic signed [JAC_W-1:0]  jac_det;
  } gft_in_t;

  typedef struct packed {
    logic signed [GEO_W-1:0] geo_00;
    logic signed [GEO_W-1:0] geo_01;
    logic signed [GEO_W-1:0] geo_02;
    logic signed [GEO_W-1:0] geo_11;
    logic signed [GEO_W-1:0] geo_12;
    logic signed [GEO_W-1:0] geo_22;
    logic                    singular;
  } gft_out_t;

  // Latency of gft_smul for a first operand of the given width.
  function automatic int mul_lat(input int wa);
    return 2 * ((wa + LIMB_W - 1) / LIMB_W) + 2;
  endfunction

  // Row and column of the i-th unique metric entry.
  function automatic int gram_row(input int i);
    int r;
    case (i)
      0, 1, 2: r = 0;
      3, 4:    r = 1;
      default: r = 2;
    endcase
    return r;
  endfunction

  function automatic int gram_col(input int i);
    int c;
    case (i)
      0:       c = 0;
      1, 3:    c = 1;
      default: c = 2;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/gft_delay.sv
// ----------------------------------------------------------------------------
// Geometric factor tensor delay line
// Fixed-depth register line that aligns side data with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module gft_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [D];

  always_ff @(posedge clk) begin
    pipe_r[0] <= d;
    for (int i = 1; i < D; i++) begin
      pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign q = pipe_r[D-1];

endmodule

`default_nettype wire

// File: rtl/gft_smul.sv
// ----------------------------------------------------------------------------
// Geometric factor tensor signed multiplier
// Sign-magnitude limb multiplier: one 32-bit limb of a per two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gft_smul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic                    out_vld,
  output logic signed [WA+WB-1:0] p
);

  localparam int LW   = gft_pkg::LIMB_W;
  localparam int NA   = (WA + LW - 1) / LW;
  localparam int NB   = (WB + LW - 1) / LW;
  localparam int WAP  = NA * LW;
  localparam int WBP  = NB * LW;
  localparam int WACC = WAP + WBP;
  localparam int WP   = WA + WB;
  localparam int WROW = WBP + LW;

  logic [WA-1:0] amag;
  logic [WB-1:0] bmag;

  logic            vld_r [NA+1];
  logic            neg_r [NA+1];
  logic [WAP-1:0]  ma_r  [NA+1];
  logic [WBP-1:0]  mb_r  [NA+1];
  logic [WACC-1:0] acc_r [NA+1];

  logic            vm_r   [NA];
  logic            nm_r   [NA];
  logic [WAP-1:0]  mam_r  [NA];
  logic [WBP-1:0]  mbm_r  [NA];
  logic [WACC-1:0] accm_r [NA];
  logic [2*LW-1:0] pp_r   [NA][NB];

  logic          out_vld_r;
  logic [WP-1:0] p_r;

  always_comb begin
    amag = a[WA-1] ? (~a + 1'b1) : a;
    bmag = b[WB-1] ? (~b + 1'b1) : b;
  end

  // take magnitudes and the product sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    neg_r[0] <= a[WA-1] ^ b[WB-1];
    ma_r[0]  <= WAP'(amag);
    mb_r[0]  <= WBP'(bmag);
    acc_r[0] <= '0;
  end

  for (genvar k = 0; k < NA; k++) begin : g_limb
    logic [WROW-1:0] even_sum;
    logic [WROW-1:0] odd_sum;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vm_r[k] <= 1'b0;
      end else begin
        vm_r[k] <= vld_r[k];
      end
    end

    // partial products of limb k against every limb of b
    always_ff @(posedge clk) begin
      nm_r[k]   <= neg_r[k];
      mam_r[k]  <= ma_r[k];
      mbm_r[k]  <= mb_r[k];
      accm_r[k] <= acc_r[k];
      for (int j = 0; j < NB; j++) begin
        pp_r[k][j] <= ma_r[k][k*LW +: LW] * mb_r[k][j*LW +: LW];
      end
    end

    // even and odd partial products do not overlap within their group
    always_comb begin
      even_sum = '0;
      odd_sum  = '0;
      for (int j = 0; j < NB; j++) begin
        if (j[0] == 1'b0) begin
          even_sum[j*LW +: 2*LW] = pp_r[k][j];
        end else begin
          odd_sum[j*LW +: 2*LW] = pp_r[k][j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vm_r[k];
      end
    end

    always_ff @(posedge clk) begin
      neg_r[k+1] <= nm_r[k];
      ma_r[k+1]  <= mam_r[k];
      mb_r[k+1]  <= mbm_r[k];
      acc_r[k+1] <= accm_r[k] + (WACC'(even_sum + odd_sum) << (k * LW));
    end
  end

  // restore the sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[NA];
    end
  end

  always_ff @(posedge clk) begin
    p_r <= neg_r[NA] ? WP'(~acc_r[NA] + 1'b1) : WP'(acc_r[NA]);
  end

  assign out_vld = out_vld_r;
  assign p       = p_r;

endmodule

`default_nettype wire

// File: rtl/gft_div.sv
// ----------------------------------------------------------------------------
// Geometric factor tensor divider
// Pipelined restoring divider, one quotient bit per stage, 64-bit saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module gft_div #(
  parameter int NW = 64,
  parameter int DW = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic signed [NW-1:0]                num,
  input  logic [DW-1:0]                       den,
  output logic                                out_vld,
  output logic signed [gft_pkg::GEO_W-1:0]    quo
);

  localparam int QW = gft_pkg::GEO_W;
  localparam int WR = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] nmag;

  logic          va_r;
  logic          na_r;
  logic [WR-1:0] ra_r;
  logic [DW-1:0] da_r;

  logic          vld_r [QW+1];
  logic          neg_r [QW+1];
  logic          ovf_r [QW+1];
  logic [WR-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];

  logic          out_vld_r;
  logic [QW-1:0] quo_r;
  logic [QW-1:0] quo_nxt;

  assign nmag = num[NW-1] ? (~num + 1'b1) : num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= 1'b0;
      vld_r[0] <= 1'b0;
    end else begin
      va_r     <= in_vld;
      vld_r[0] <= va_r;
    end
  end

  // magnitude, then the range check: a quotient of 2^64 or more saturates
  always_ff @(posedge clk) begin
    na_r     <= num[NW-1];
    ra_r     <= WR'(nmag);
    da_r     <= den;
    neg_r[0] <= na_r;
    ovf_r[0] <= ra_r >= (WR'(da_r) << QW);
    rem_r[0] <= ra_r;
    den_r[0] <= da_r;
    q_r[0]   <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int BIT = QW - 1 - k;
    logic [WR-1:0] shd;
    logic          ge;

    assign shd = WR'(den_r[k]) << BIT;
    assign ge  = rem_r[k] >= shd;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
      den_r[k+1] <= den_r[k];
      rem_r[k+1] <= ge ? (rem_r[k] - shd) : rem_r[k];
      q_r[k+1]   <= q_r[k] | (QW'(ge) << BIT);
    end
  end

  always_comb begin
    if (ovf_r[QW]) begin
      quo_nxt = neg_r[QW] ? gft_pkg::Q_MIN : gft_pkg::Q_MAX;
    end else if (!neg_r[QW]) begin
      quo_nxt = q_r[QW][QW-1] ? gft_pkg::Q_MAX : q_r[QW];
    end else if (q_r[QW] > gft_pkg::Q_MIN) begin
      quo_nxt = gft_pkg::Q_MIN;
    end else begin
      quo_nxt = ~q_r[QW] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign out_vld = out_vld_r;
  assign quo     = quo_r;

endmodule

`default_nettype wire

// File: rtl/geometric_factor_tensor.sv
// ----------------------------------------------------------------------------
// Geometric factor tensor
// Scaled metric inv(J)^T inv(J) * w * det for one quadrature point per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive start with one beat on in_data (nine Jacobian
//   entries, weight, given determinant). A beat is taken at every rising
//   edge with start high and busy low; busy never rises, so one point can
//   enter in every cycle.
//   Result channel: out_strobe is high for one cycle with the six unique
//   metric entries and the singular flag on out_data. The receiver cannot
//   stall; results leave in input order.
//   Pipeline: the exact ratio goes through limb multipliers (two stages
//   per 32-bit limb) and a 64-stage restoring divider; the divider sets
//   most of the depth, and out_strobe is registered after the divider.
//   Throughput: one point per cycle.
//   Reset: rst_n low clears every valid bit, so no strobe leaves for beats
//   in flight; data registers keep stale contents that are never shown.
//   Singular matrix: a computed determinant of zero gives all-zero entries
//   with singular set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "geometric_factor_tensor_defines.svh"

module geometric_factor_tensor #(
  parameter int FRAC_BITS = gft_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gft_pkg::gft_in_t  in_data,
  output logic              out_strobe,
  output gft_pkg::gft_out_t out_data
);

  localparam int JW    = gft_pkg::JAC_W;
  localparam int WW    = gft_pkg::WEIGHT_W;
  localparam int GW    = gft_pkg::GEO_W;
  localparam int W_CP  = 2 * JW;
  localparam int W_COF = W_CP + 1;
  localparam int W_DP  = JW + W_COF;
  localparam int W_DET = W_DP + 2;
  localparam int W_GP  = 2 * W_COF;
  localparam int W_S   = W_GP + 2;
  localparam int W_SP  = WW + 1 + JW;
  localparam int W_SC  = W_SP + FRAC_BITS;
  localparam int W_NUM = W_S + W_SC;
  localparam int W_DEN = 2 * W_DET;

  // pipeline timing, in edges after the accepting edge
  localparam int T_COF  = gft_pkg::mul_lat(JW) + 1;
  localparam int T_DET  = T_COF + gft_pkg::mul_lat(JW) + 1;
  localparam int T_SING = T_DET + 1;
  localparam int T_S    = T_COF + gft_pkg::mul_lat(W_COF) + 1;
  localparam int T_DEN  = T_DET + gft_pkg::mul_lat(W_DET);
  localparam int T_SC   = gft_pkg::mul_lat(WW + 1) + 1;
  localparam int T_NUM  = T_S + gft_pkg::mul_lat(W_S);
  localparam int T_QUO  = T_NUM + gft_pkg::DIV_LAT;
  localparam int LAT_TOTAL = T_QUO + 2;

  // input stage
  logic             in_v_r;
  gft_pkg::gft_in_t in_r;
  logic signed [JW-1:0] jac_a [3][3];
  logic signed [WW:0]   wgt_s;

  // cofactors
  logic signed [W_CP-1:0]  cp1 [3][3];
  logic signed [W_CP-1:0]  cp2 [3][3];
  logic                    cp_vld;
  logic                    cof_v_r;
  logic signed [W_COF-1:0] cof_r [3][3];

  // determinant
  logic [3*JW-1:0]         row0_d;
  logic signed [W_DP-1:0]  dp [3];
  logic                    dp_vld;
  logic                    det_v_r;
  logic signed [W_DET-1:0] det_r;
  logic                    sing_r;
  logic                    sing_d;

  // gram sums
  logic signed [W_GP-1:0] gp [6][3];
  logic                   gp_vld;
  logic                   s_v_r;
  logic signed [W_S-1:0]  s_r [6];

  // scale and denominator
  logic signed [W_SP-1:0]  sp;
  logic signed [W_SC-1:0]  scale_r;
  logic [W_SC-1:0]         scale_d;
  logic signed [W_DEN-1:0] den_p;
  logic [W_DEN-1:0]        den_d;

  // numerators and quotients
  logic signed [W_NUM-1:0] num [6];
  logic signed [GW-1:0]    quo [6];
  logic                    quo_vld;

  logic              out_strobe_r;
  gft_pkg::gft_out_t out_data_r;
  gft_pkg::gft_out_t out_nxt;

  // sign checks for the assertions
  logic              det_neg;
  logic              diag_chk;

  // every beat is taken as it comes
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  always_comb begin
    jac_a[0][0] = in_r.jac_00;
    jac_a[0][1] = in_r.jac_01;
    jac_a[0][2] = in_r.jac_02;
    jac_a[1][0] = in_r.jac_10;
    jac_a[1][1] = in_r.jac_11;
    jac_a[1][2] = in_r.jac_12;
    jac_a[2][0] = in_r.jac_20;
    jac_a[2][1] = in_r.jac_21;
    jac_a[2][2] = in_r.jac_22;
  end

  assign wgt_s = {1'b0, in_r.quad_weight};

  // Cofactors: cyclic row and column order carries the sign.
  for (genvar r = 0; r < 3; r++) begin : g_cof_r
    for (genvar c = 0; c < 3; c++) begin : g_cof_c
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      logic p1_vld;

      gft_smul #(.WA(JW), .WB(JW)) u_p1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_v_r),
        .a       (jac_a[R1][C1]),
        .b       (jac_a[R2][C2]),
        .out_vld (p1_vld),
        .p       (cp1[r][c])
      );

      gft_smul #(.WA(JW), .WB(JW)) u_p2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_v_r),
        .a       (jac_a[R1][C2]),
        .b       (jac_a[R2][C1]),
        .out_vld (),
        .p       (cp2[r][c])
      );

      if (r == 0 && c == 0) begin : g_vld
        assign cp_vld = p1_vld;
      end

      always_ff @(posedge clk) begin
        cof_r[r][c] <= W_COF'(cp1[r][c]) - W_COF'(cp2[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cof_v_r <= 1'b0;
    end else begin
      cof_v_r <= cp_vld;
    end
  end

  // hold row 0 of J until its cofactors are ready
  gft_delay #(.W(3 * JW), .D(T_COF)) u_row0_dly (
    .clk (clk),
    .d   ({in_r.jac_00, in_r.jac_01, in_r.jac_02}),
    .q   (row0_d)
  );

  // Determinant: expansion along row 0.
  for (genvar k = 0; k < 3; k++) begin : g_det
    logic dv;

    gft_smul #(.WA(JW), .WB(W_COF)) u_dp (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (cof_v_r),
      .a       (signed'(row0_d[(2-k)*JW +: JW])),
      .b       (cof_r[0][k]),
      .out_vld (dv),
      .p       (dp[k])
    );

    if (k == 0) begin : g_vld
      assign dp_vld = dv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_v_r <= 1'b0;
    end else begin
      det_v_r <= dp_vld;
    end
  end

  always_ff @(posedge clk) begin
    det_r  <= W_DET'(dp[0]) + W_DET'(dp[1]) + W_DET'(dp[2]);
    sing_r <= det_r == '0;
  end

  gft_delay #(.W(1), .D(T_QUO - T_SING)) u_sing_dly (
    .clk (clk),
    .d   (sing_r),
    .q   (sing_d)
  );

  // Gram sums of cofactor rows: six unique entries, three products each.
  for (genvar i = 0; i < 6; i++) begin : g_gram
    localparam int GL = gft_pkg::gram_row(i);
    localparam int GM = gft_pkg::gram_col(i);

    for (genvar k = 0; k < 3; k++) begin : g_term
      logic gv;

      gft_smul #(.WA(W_COF), .WB(W_COF)) u_gp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (cof_v_r),
        .a       (cof_r[GL][k]),
        .b       (cof_r[GM][k]),
        .out_vld (gv),
        .p       (gp[i][k])
      );

      if (i == 0 && k == 0) begin : g_vld
        assign gp_vld = gv;
      end
    end

    always_ff @(posedge clk) begin
      s_r[i] <= W_S'(gp[i][0]) + W_S'(gp[i][1]) + W_S'(gp[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= gp_vld;
    end
  end

  // Denominator: det squared, always non-negative.
  gft_smul #(.WA(W_DET), .WB(W_DET)) u_den (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (det_v_r),
    .a       (det_r),
    .b       (det_r),
    .out_vld (),
    .p       (den_p)
  );

  gft_delay #(.W(W_DEN), .D(T_NUM - T_DEN)) u_den_dly (
    .clk (clk),
    .d   (den_p),
    .q   (den_d)
  );

  // Scale: weight times given determinant, lifted by the fraction bits.
  gft_smul #(.WA(WW + 1), .WB(JW)) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_v_r),
    .a       (wgt_s),
    .b       (in_r.jac_det),
    .out_vld (),
    .p       (sp)
  );

  always_ff @(posedge clk) begin
    scale_r <= W_SC'(sp) << FRAC_BITS;
  end

  gft_delay #(.W(W_SC), .D(T_S - T_SC)) u_scale_dly (
    .clk (clk),
    .d   (scale_r),
    .q   (scale_d)
  );

  // Numerators and exact quotients.
  for (genvar i = 0; i < 6; i++) begin : g_quo
    logic nv;
    logic qv;

    gft_smul #(.WA(W_S), .WB(W_SC)) u_num (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (s_v_r),
      .a       (s_r[i]),
      .b       (signed'(scale_d)),
      .out_vld (nv),
      .p       (num[i])
    );

    gft_div #(.NW(W_NUM), .DW(W_DEN)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (nv),
      .num     (num[i]),
      .den     (den_d),
      .out_vld (qv),
      .quo     (quo[i])
    );

    if (i == 0) begin : g_vld
      assign quo_vld = qv;
    end
  end

  // Output register: drop the quotients of a singular matrix.
  always_comb begin
    out_nxt.geo_00   = sing_d ? '0 : quo[0];
    out_nxt.geo_01   = sing_d ? '0 : quo[1];
    out_nxt.geo_02   = sing_d ? '0 : quo[2];
    out_nxt.geo_11   = sing_d ? '0 : quo[3];
    out_nxt.geo_12   = sing_d ? '0 : quo[4];
    out_nxt.geo_22   = sing_d ? '0 : quo[5];
    out_nxt.singular = sing_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= quo_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  assign det_neg  = in_data.jac_det[JW-1];
  assign diag_chk = out_strobe &&
                    (out_data.geo_00[GW-1] || out_data.geo_11[GW-1] || out_data.geo_22[GW-1]);

  // every accepted beat leaves after the fixed latency
  `GFT_ASSERT_DELAY(a_beat_out, start && !busy, LAT_TOTAL, out_strobe, "accepted beat did not leave")
  // no result without a beat accepted at the matching edge
  `GFT_ASSERT_IMPL(a_no_ghost, out_strobe, $past(start, LAT_TOTAL), "result without a beat")
  // a negative diagonal entry needs a negative given determinant
  `GFT_ASSERT_IMPL(a_diag_sign, diag_chk, $past(det_neg, LAT_TOTAL), "diagonal sign mismatch")

endmodule

`default_nettype wire

// File: sim/tb_geometric_factor_tensor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Geometric factor tensor testbench
// Streams Jacobian points into the block with random gaps, predicts each
// scaled metric result with exact wide integer arithmetic and checks every
// strobed result beat field by field in input order.
// ----------------------------------------------------------------------------
module tb_geometric_factor_tensor;

  localparam int FRAC   = gft_pkg::FRAC_BITS_DEF;
  localparam int ONE    = 1 << FRAC;
  localparam int GW     = gft_pkg::GEO_W;
  localparam int WW     = gft_pkg::WEIGHT_W;
  localparam int STALL_LIMIT = 4000;
  localparam int LAT_SLACK   = 200;

  typedef logic signed [255:0] wide_t;

  // One queued point: payload, cycles to idle before it, and whether the
  // driver must first drain every outstanding result.
  typedef struct {
    gft_pkg::gft_in_t beat;
    int               gap;
    bit               drain;
  } point_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  gft_pkg::gft_in_t  in_data;
  logic              out_strobe;
  gft_pkg::gft_out_t out_data;

  point_t            point_q[$];
  gft_pkg::gft_out_t metric_q[$];
  bit                beat_taken;
  bit                failed;
  int                gap_left;
  int                quiet_cycles;

  geometric_factor_tensor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate a signed quotient to the 64-bit result range.
  function automatic logic [GW-1:0] clamp_quot(input wide_t num, input wide_t den);
    wide_t mag;
    wide_t q;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    if (num < 0) begin
      if (q > (wide_t'(1) <<< 63)) return gft_pkg::Q_MIN;
      return GW'(-q);
    end
    if (q > ((wide_t'(1) <<< 63) - 1)) return gft_pkg::Q_MAX;
    return GW'(q);
  endfunction

  // Exact metric: (C C^T)_lm * w * jd * 2^F / det^2, truncated then saturated.
  function automatic gft_pkg::gft_out_t metric_of(input gft_pkg::gft_in_t p);
    wide_t             a [3][3];
    wide_t             cof [3][3];
    wide_t             det;
    wide_t             scale;
    wide_t             s;
    gft_pkg::gft_out_t r;
    logic [GW-1:0]     g [6];
    a[0][0] = wide_t'(p.jac_00); a[0][1] = wide_t'(p.jac_01); a[0][2] = wide_t'(p.jac_02);
    a[1][0] = wide_t'(p.jac_10); a[1][1] = wide_t'(p.jac_11); a[1][2] = wide_t'(p.jac_12);
    a[2][0] = wide_t'(p.jac_20); a[2][1] = wide_t'(p.jac_21); a[2][2] = wide_t'(p.jac_22);
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        // cyclic indexing carries the cofactor sign
        cof[rr][cc] = a[(rr+1)%3][(cc+1)%3] * a[(rr+2)%3][(cc+2)%3]
                    - a[(rr+1)%3][(cc+2)%3] * a[(rr+2)%3][(cc+1)%3];
      end
    end
    det = 0;
    for (int k = 0; k < 3; k++) det = det + a[0][k] * cof[0][k];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    scale = wide_t'({1'b0, p.quad_weight}) * wide_t'(p.jac_det);
    scale = scale <<< FRAC;
    for (int i = 0; i < 6; i++) begin
      s = 0;
      for (int k = 0; k < 3; k++) begin
        s = s + cof[gft_pkg::gram_row(i)][k] * cof[gft_pkg::gram_col(i)][k];
      end
      g[i] = clamp_quot(s * scale, det * det);
    end
    r.geo_00 = g[0]; r.geo_01 = g[1]; r.geo_02 = g[2];
    r.geo_11 = g[3]; r.geo_12 = g[4]; r.geo_22 = g[5];
    return r;
  endfunction

  function automatic gft_pkg::gft_in_t mk_point(input int d0, input int d1, input int d2,
                                                input int off, input int w, input int jd);
    gft_pkg::gft_in_t p;
    p = '0;
    p.jac_00 = d0;  p.jac_01 = off; p.jac_02 = -off;
    p.jac_10 = off; p.jac_11 = d1;  p.jac_12 = off;
    p.jac_20 = 0;   p.jac_21 = -off; p.jac_22 = d2;
    p.quad_weight = WW'(w);
    p.jac_det = jd;
    return p;
  endfunction

  function automatic gft_pkg::gft_in_t rand_point();
    gft_pkg::gft_in_t p;
    p.jac_00 = $urandom; p.jac_01 = $urandom; p.jac_02 = $urandom;
    p.jac_10 = $urandom; p.jac_11 = $urandom; p.jac_12 = $urandom;
    p.jac_20 = $urandom; p.jac_21 = $urandom; p.jac_22 = $urandom;
    p.quad_weight = WW'($urandom);
    p.jac_det = $urandom;
    return p;
  endfunction

  // Mildly distorted element: diagonal near 1.0, small off-diagonal terms.
  function automatic gft_pkg::gft_in_t shaped_point();
    gft_pkg::gft_in_t p;
    int span;
    span = ONE >> $urandom_range(0, 6);
    p.jac_00 = ONE + $signed($urandom_range(0, 2*span)) - span;
    p.jac_11 = ONE + $signed($urandom_range(0, 2*span)) - span;
    p.jac_22 = ONE + $signed($urandom_range(0, 2*span)) - span;
    p.jac_01 = $signed($urandom_range(0, span)) - span/2;
    p.jac_02 = $signed($urandom_range(0, span)) - span/2;
    p.jac_10 = $signed($urandom_range(0, span)) - span/2;
    p.jac_12 = $signed($urandom_range(0, span)) - span/2;
    p.jac_20 = $signed($urandom_range(0, span)) - span/2;
    p.jac_21 = $signed($urandom_range(0, span)) - span/2;
    p.quad_weight = WW'($urandom_range(0, 524288));
    p.jac_det = $signed($urandom_range(0, 4*ONE)) - 2*ONE;
    return p;
  endfunction

  task automatic add_point(input gft_pkg::gft_in_t p, input int gap, input bit drain);
    point_t e;
    e.beat = p;
    e.gap = gap;
    e.drain = drain;
    point_q.push_back(e);
  endtask

  task automatic check_field(input string name, input logic [GW-1:0] exp_v,
                             input logic [GW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  // Driver: advance on the falling edge; one assignment of start per step.
  always @(negedge clk) begin
    logic nxt_start;
    nxt_start = start;
    if (beat_taken) begin
      beat_taken = 1'b0;
      nxt_start = 1'b0;
    end
    if (!nxt_start && rst_n && point_q.size() > 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (!point_q[0].drain || metric_q.size() == 0) begin
        in_data <= point_q[0].beat;
        nxt_start = 1'b1;
        point_q.pop_front();
        gap_left = (point_q.size() > 0) ? point_q[0].gap : 0;
      end
    end
    start <= nxt_start;
  end

  // Monitor: take input beats, predict, and check strobed results.
  always @(posedge clk) begin
    gft_pkg::gft_out_t exp_r;
    if (rst_n) begin
      quiet_cycles++;
      if (start && !busy) begin
        metric_q.push_back(metric_of(in_data));
        beat_taken = 1'b1;
        quiet_cycles = 0;
      end
      if (out_strobe) begin
        quiet_cycles = 0;
        if (metric_q.size() == 0) begin
          $error("result beat with nothing expected");
          failed = 1'b1;
        end else begin
          exp_r = metric_q.pop_front();
          check_field("geo_00", exp_r.geo_00, out_data.geo_00);
          check_field("geo_01", exp_r.geo_01, out_data.geo_01);
          check_field("geo_02", exp_r.geo_02, out_data.geo_02);
          check_field("geo_11", exp_r.geo_11, out_data.geo_11);
          check_field("geo_12", exp_r.geo_12, out_data.geo_12);
          check_field("geo_22", exp_r.geo_22, out_data.geo_22);
          check_field("singular", GW'(exp_r.singular), GW'(out_data.singular));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    gft_pkg::gft_in_t p;
    int gap;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    beat_taken = 1'b0;
    failed = 1'b0;
    gap_left = 0;
    quiet_cycles = 0;

    // Directed points: identity, extremes, singular and scale corner cases.
    add_point(mk_point(ONE, ONE, ONE, 0, ONE, ONE), 0, 0);
    add_point(mk_point(2*ONE, ONE/2, ONE, ONE/4, 524288, ONE), 0, 0);
    add_point(mk_point(ONE, ONE, ONE, 0, 0, ONE), 0, 0);
    add_point(mk_point(ONE, ONE, ONE, 0, ONE, 0), 0, 0);
    add_point(mk_point(ONE, ONE, ONE, 0, 20'hFFFFF, 32'h7FFFFFFF), 0, 0);
    add_point(mk_point(ONE, ONE, ONE, 0, 20'hFFFFF, 32'h80000000), 0, 0);
    add_point(mk_point(1, 1, 1, 0, 20'hFFFFF, 32'h7FFFFFFF), 0, 0);
    add_point(mk_point(1, 1, 1, 0, 20'hFFFFF, 32'h80000000), 0, 0);
    add_point(mk_point(-ONE, ONE, ONE, ONE/8, ONE, -ONE), 0, 0);
    add_point(mk_point(0, ONE, ONE, 0, ONE, ONE), 0, 0);
    p = '1;
    add_point(p, 0, 0);
    p = '0;
    add_point(p, 0, 0);
    for (int i = 0; i < 4; i++) begin
      p = '0;
      {p.jac_00, p.jac_01, p.jac_02} = {3{32'h7FFFFFFF}};
      {p.jac_10, p.jac_11, p.jac_12} = {3{32'h80000000}};
      {p.jac_20, p.jac_21, p.jac_22} = {32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
      if (i[0]) p.jac_22 = 32'h80000000;
      p.quad_weight = i[1] ? 20'hFFFFF : 20'd0;
      p.jac_det = i[1] ? 32'h7FFFFFFF : 32'h80000000;
      add_point(p, 0, 0);
    end
    // Duplicate rows make the matrix singular with a nonzero scale.
    p = rand_point();
    {p.jac_20, p.jac_21, p.jac_22} = {p.jac_00, p.jac_01, p.jac_02};
    add_point(p, 0, 1);

    // Random points: mostly well-shaped elements, some raw bit noise.
    for (int i = 0; i < 550; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    p = rand_point();
        2: begin
          p = shaped_point();
          {p.jac_10, p.jac_11, p.jac_12} = {p.jac_00, p.jac_01, p.jac_02};
        end
        default: p = shaped_point();
      endcase
      // hold back-to-back stretches between idle-heavy ones
      gap = ((i / 60) % 2 == 0) ? 0 : $urandom_range(0, 10);
      add_point(p, gap, (i % 137) == 136);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (point_q.size() == 0 && !start);
    wait (metric_q.size() == 0);
    repeat (LAT_SLACK) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
